@@ rtl/core/ssa_pkg.sv @@
// Shared types and constants for the slot allocator.
package ssa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int ADDR_W    = $clog2(MAX_SLOTS);
  localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1);
  localparam int OFS_W     = 20;
  localparam int CNT_W     = 11;
  localparam int BYTES_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;

  localparam logic [OFS_W-1:0] MARKER = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 1'b1;

  localparam logic [CNT_W-1:0]   SLOT_COUNT_RST = 11'd1024;
  localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 9'd32;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NO_SLOTS    = 2'd1,
    ERR_FREE_MARKER = 2'd2,
    ERR_STACK_FULL  = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [OFS_W-1:0]  wdata;
  } ram_req_t;

  typedef struct packed {
    logic               busy;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] next_fresh;
  } status_t;

endpackage

@@ rtl/core/ssa_stack_ram.sv @@
// Free stack storage: single-port synchronous RAM, registered read.
module ssa_stack_ram (
  input  logic                     clk,
  input  ssa_pkg::ram_req_t        req,
  output logic [ssa_pkg::OFS_W-1:0] rdata
);

  logic [ssa_pkg::OFS_W-1:0] mem [ssa_pkg::MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ rtl/core/ssa_ctrl.sv @@
// Allocator control: config registers, stack pointer, bump counter, result register.
module ssa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [ssa_pkg::OFS_W-1:0]     offset_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [ssa_pkg::OFS_W-1:0]     offset_out,
  output logic [1:0]                    error_code,
  output ssa_pkg::ram_req_t             ram_req,
  input  logic [ssa_pkg::OFS_W-1:0]     ram_rdata,
  output ssa_pkg::status_t              status
);

  localparam int PROD_W = ssa_pkg::DEPTH_W + ssa_pkg::BYTES_W;

  ssa_pkg::state_t state, state_next;

  logic [ssa_pkg::CNT_W-1:0]   slot_count;
  logic [ssa_pkg::BYTES_W-1:0] slot_bytes;
  logic [ssa_pkg::DEPTH_W-1:0] depth, depth_next;
  logic [ssa_pkg::DEPTH_W-1:0] next_fresh, next_fresh_next;
  logic [ssa_pkg::DEPTH_W-1:0] limit;
  logic [ssa_pkg::DEPTH_W-1:0] depth_m1;
  logic [PROD_W-1:0]           fresh_prod;

  logic                      res_load;
  logic                      res_ok;
  logic [ssa_pkg::OFS_W-1:0] res_ofs;
  ssa_pkg::err_t             res_err;
  ssa_pkg::err_t             err_reg;

  logic accept;
  logic out_free;
  logic do_pop;
  logic busy;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign depth_m1 = depth - ssa_pkg::DEPTH_W'(1);
  assign do_pop   = accept && (operation == ssa_pkg::OP_ALLOC) && (depth != '0);

  assign limit = (32'(slot_count) > ssa_pkg::MAX_SLOTS)
               ? ssa_pkg::DEPTH_W'(ssa_pkg::MAX_SLOTS)
               : ssa_pkg::DEPTH_W'(slot_count);

  assign fresh_prod = PROD_W'(next_fresh) * PROD_W'(slot_bytes);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssa_pkg::ST_IDLE: begin
        if (do_pop) begin
          state_next = ssa_pkg::ST_POP;
        end
      end
      ssa_pkg::ST_POP: state_next = ssa_pkg::ST_IDLE;
      default:         state_next = ssa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    busy     = 1'b0;
    unique case (state)
      ssa_pkg::ST_IDLE: in_ready = out_free;
      ssa_pkg::ST_POP:  busy     = 1'b1;
      default:          in_ready = 1'b0;
    endcase
  end

  assign status.busy       = busy;
  assign status.depth      = depth;
  assign status.next_fresh = next_fresh;

  // transaction decode
  always_comb begin
    res_load        = 1'b0;
    res_ok          = 1'b0;
    res_ofs         = ssa_pkg::MARKER;
    res_err         = ssa_pkg::ERR_NONE;
    depth_next      = depth;
    next_fresh_next = next_fresh;
    ram_req.we      = 1'b0;
    ram_req.re      = 1'b0;
    ram_req.addr    = depth[ssa_pkg::ADDR_W-1:0];
    ram_req.wdata   = offset_in;
    if (state == ssa_pkg::ST_POP) begin
      res_load = 1'b1;
      res_ok   = 1'b1;
      res_ofs  = ram_rdata;
    end else if (accept) begin
      if (operation == ssa_pkg::OP_ALLOC) begin
        if (depth != '0) begin
          ram_req.re   = 1'b1;
          ram_req.addr = depth_m1[ssa_pkg::ADDR_W-1:0];
          depth_next   = depth_m1;
        end else if (next_fresh >= limit) begin
          res_load = 1'b1;
          res_err  = ssa_pkg::ERR_NO_SLOTS;
        end else begin
          res_load        = 1'b1;
          res_ok          = 1'b1;
          res_ofs         = ssa_pkg::OFS_W'(fresh_prod);
          next_fresh_next = next_fresh + ssa_pkg::DEPTH_W'(1);
        end
      end else begin
        res_load = 1'b1;
        if (offset_in == ssa_pkg::MARKER) begin
          res_err = ssa_pkg::ERR_FREE_MARKER;
        end else if (depth == ssa_pkg::DEPTH_W'(ssa_pkg::MAX_SLOTS)) begin
          res_ofs = offset_in;
          res_err = ssa_pkg::ERR_STACK_FULL;
        end else begin
          res_ok     = 1'b1;
          ram_req.we = 1'b1;
          depth_next = depth + ssa_pkg::DEPTH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ssa_pkg::ST_IDLE;
      depth      <= '0;
      next_fresh <= '0;
      slot_count <= ssa_pkg::SLOT_COUNT_RST;
      slot_bytes <= ssa_pkg::SLOT_BYTES_RST;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      depth      <= depth_next;
      next_fresh <= next_fresh_next;
      if (cfg_write) begin
        unique case (cfg_index)
          ssa_pkg::REG_SLOT_COUNT: slot_count <= ssa_pkg::CNT_W'(cfg_data);
          ssa_pkg::REG_SLOT_BYTES: slot_bytes <= ssa_pkg::BYTES_W'(cfg_data);
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      ok         <= res_ok;
      offset_out <= res_ofs;
      err_reg    <= res_err;
    end
  end

  assign error_code = err_reg;

endmodule

@@ rtl/core/slot_allocator_free_stack.sv @@
// Free and fresh allocate results are registered in the cycle after acceptance;
// a pop also passes through the stack RAM read register before the result register.
// Throughput: one transaction per cycle unless out_ready holds the result, except that
// a pop holds off the next transaction in ST_POP while the RAM read completes.
// Reset: stack depth and bump index go to zero, slot_count to 1024, slot_bytes to 32;
// the stack RAM is not cleared, since only entries below the depth are read.
module slot_allocator_free_stack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [ssa_pkg::OFS_W-1:0]     offset_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [ssa_pkg::OFS_W-1:0]     offset_out,
  output logic [1:0]                    error_code
);

  ssa_pkg::ram_req_t         ram_req;
  logic [ssa_pkg::OFS_W-1:0] ram_rdata;
  ssa_pkg::status_t          status;

  ssa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .offset_in  (offset_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .offset_out (offset_out),
    .error_code (error_code),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .status     (status)
  );

  ssa_stack_ram u_stack_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(status.depth) <= ssa_pkg::MAX_SLOTS)
    else $error("free stack depth beyond capacity");

  a_ok_vs_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (error_code == ssa_pkg::ERR_NONE)))
    else $error("ok and error code disagree");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !in_ready)
    else $error("transaction accepted during stack read");

  a_fresh_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> status.next_fresh >= $past(status.next_fresh))
    else $error("bump index went backwards");

  a_no_ram_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("stack RAM read and write in one cycle");

endmodule

@@ tb/sv/tb_slot_allocator_free_stack.sv @@
// Testbench for slot_allocator_free_stack: directed and random requests, predictor-checked.
`timescale 1ns / 1ps

module tb_slot_allocator_free_stack;

  typedef struct packed {
    logic                      ok;
    logic [ssa_pkg::OFS_W-1:0] offset;
    ssa_pkg::err_t             code;
  } alloc_reply_t;

  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          cfg_write  = 1'b0;
  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index  = ssa_pkg::REG_SLOT_COUNT;
  logic [ssa_pkg::CFG_W-1:0]     cfg_data   = '0;
  logic                          in_valid   = 1'b0;
  logic                          in_ready;
  logic                          operation  = ssa_pkg::OP_ALLOC;
  logic [ssa_pkg::OFS_W-1:0]     offset_in  = '0;
  logic                          out_valid;
  logic                          out_ready  = 1'b0;
  logic                          ok;
  logic [ssa_pkg::OFS_W-1:0]     offset_out;
  logic [1:0]                    error_code;

  // predictor state
  logic [ssa_pkg::OFS_W-1:0]   free_store [ssa_pkg::MAX_SLOTS];
  int unsigned                 stack_depth = 0;
  int unsigned                 fresh_index = 0;
  logic [ssa_pkg::CNT_W-1:0]   heap_slots  = ssa_pkg::SLOT_COUNT_RST;
  logic [ssa_pkg::BYTES_W-1:0] slot_stride = ssa_pkg::SLOT_BYTES_RST;

  alloc_reply_t              expected_replies [$];
  logic [ssa_pkg::OFS_W-1:0] live_handles [$];
  int                        mismatch_count = 0;
  logic                      no_idle = 1'b0;

  slot_allocator_free_stack u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .offset_in  (offset_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .offset_out (offset_out),
    .error_code (error_code)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 26);
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic alloc_reply_t predict_reply(input logic op,
                                                 input logic [ssa_pkg::OFS_W-1:0] ofs);
    alloc_reply_t     r;
    int unsigned      cap;
    longint unsigned  fresh;
    r.ok     = 1'b0;
    r.offset = ssa_pkg::MARKER;
    r.code   = ssa_pkg::ERR_NONE;
    if (op == ssa_pkg::OP_ALLOC) begin
      if (stack_depth > 0) begin
        stack_depth--;
        r.ok     = 1'b1;
        r.offset = free_store[stack_depth[ssa_pkg::ADDR_W-1:0]];
      end else begin
        cap = (heap_slots > ssa_pkg::MAX_SLOTS) ? ssa_pkg::MAX_SLOTS : heap_slots;
        if (fresh_index >= cap) begin
          r.code = ssa_pkg::ERR_NO_SLOTS;
        end else begin
          fresh = longint'(fresh_index) * longint'(slot_stride);
          fresh_index++;
          r.ok     = 1'b1;
          r.offset = fresh[ssa_pkg::OFS_W-1:0];
        end
      end
    end else if (ofs == ssa_pkg::MARKER) begin
      r.code = ssa_pkg::ERR_FREE_MARKER;
    end else if (stack_depth >= ssa_pkg::MAX_SLOTS) begin
      r.offset = ofs;
      r.code   = ssa_pkg::ERR_STACK_FULL;
    end else begin
      free_store[stack_depth[ssa_pkg::ADDR_W-1:0]] = ofs;
      stack_depth++;
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // one transaction on the request channel; valid stays up for the caller
  task automatic send_request(input logic op, input logic [ssa_pkg::OFS_W-1:0] ofs);
    alloc_reply_t want;
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    offset_in <= ofs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_reply(op, ofs);
    if (op == ssa_pkg::OP_ALLOC && want.ok) live_handles.insert(live_handles.size(), want.offset);
    expected_replies.insert(expected_replies.size(), want);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_heap(input logic [ssa_pkg::CFG_W-1:0] count_word,
                              input logic [ssa_pkg::CFG_W-1:0] bytes_word);
    drain_replies();
    cfg_write <= 1'b1;
    cfg_index <= ssa_pkg::REG_SLOT_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    heap_slots = count_word[ssa_pkg::CNT_W-1:0];
    cfg_index <= ssa_pkg::REG_SLOT_BYTES;
    cfg_data  <= bytes_word;
    @(posedge clk);
    slot_stride = bytes_word[ssa_pkg::BYTES_W-1:0];
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ssa_pkg::OFS_W-1:0] pick_free_offset();
    int unsigned               roll;
    int unsigned               idx;
    logic [ssa_pkg::OFS_W-1:0] ofs;
    roll = $urandom_range(0, 99);
    if (roll < 8) return ssa_pkg::MARKER;
    if (roll < 60 && live_handles.size() > 0) begin
      idx = $urandom_range(0, live_handles.size() - 1);
      ofs = live_handles[idx];
      live_handles.delete(idx);
      return ofs;
    end
    ofs = ssa_pkg::OFS_W'($urandom);
    return ofs;
  endfunction

  always @(posedge clk) begin : check_replies
    alloc_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request pending");
      end else begin
        want = expected_replies.pop_front();
        if (ok !== want.ok)
          report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
        if (offset_out !== want.offset)
          report_mismatch($sformatf("offset_out %h, expected %h", offset_out, want.offset));
        if (error_code !== want.code)
          report_mismatch($sformatf("error_code %0d, expected %0d", error_code, want.code));
      end
    end
  end

  task automatic test_reset_defaults();
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_ALLOC, '1);
    send_request(ssa_pkg::OP_FREE, 20'h00040);
    send_request(ssa_pkg::OP_FREE, 20'h12345);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_ALLOC, 20'h5A5A5);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_FREE, ssa_pkg::MARKER);
    send_request(ssa_pkg::OP_FREE, '0);
    send_request(ssa_pkg::OP_FREE, 20'hFFFFE);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_ALLOC, '0);
  endtask

  task automatic test_out_of_slots();
    program_heap(11'd3, 11'd16);
    send_request(ssa_pkg::OP_ALLOC, '0);
    program_heap(11'd0, 11'd16);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_FREE, 20'h00005);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_ALLOC, '0);
    // slot count above the heap size is clamped
    program_heap(11'h7FF, 11'd16);
    send_request(ssa_pkg::OP_ALLOC, '0);
  endtask

  task automatic test_stride_edges();
    program_heap(11'h7FF, 11'h600);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_ALLOC, '0);
    program_heap(11'h7FF, 11'h7FF);
    send_request(ssa_pkg::OP_ALLOC, '0);
    send_request(ssa_pkg::OP_ALLOC, '0);
  endtask

  task automatic run_random_phase(input logic [ssa_pkg::CFG_W-1:0] count_word,
                                  input logic [ssa_pkg::CFG_W-1:0] bytes_word,
                                  input int n_items);
    program_heap(count_word, bytes_word);
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 55) send_request(ssa_pkg::OP_ALLOC, ssa_pkg::OFS_W'($urandom));
      else send_request(ssa_pkg::OP_FREE, pick_free_offset());
    end
  endtask

  task automatic test_random_traffic();
    no_idle = 1'b1;
    run_random_phase(11'd1024, 11'd32, 70);
    no_idle = 1'b0;
    run_random_phase(11'h7FF, 11'd511, 70);
    run_random_phase(ssa_pkg::CFG_W'(fresh_index / 2), 11'd1, 60);
    run_random_phase(11'd0, ssa_pkg::CFG_W'($urandom_range(0, 511)), 60);
    run_random_phase(ssa_pkg::CFG_W'($urandom_range(0, 2047)),
                     ssa_pkg::CFG_W'($urandom_range(0, 2047)), 70);
    run_random_phase(11'd1024, 11'd256, 70);
  endtask

  task automatic test_stack_full();
    int n_sent;
    n_sent = 0;
    program_heap(11'h7FF, 11'd1);
    no_idle = 1'b1;
    while (stack_depth < ssa_pkg::MAX_SLOTS) begin
      if (n_sent == 200) no_idle = 1'b0;
      send_request(ssa_pkg::OP_FREE,
                   ssa_pkg::OFS_W'($urandom_range(0, ssa_pkg::MARKER - 1)));
      n_sent++;
    end
    repeat (3) send_request(ssa_pkg::OP_FREE,
                            ssa_pkg::OFS_W'($urandom_range(0, ssa_pkg::MARKER - 1)));
    send_request(ssa_pkg::OP_FREE, ssa_pkg::MARKER);
    repeat (40) send_request(ssa_pkg::OP_ALLOC, ssa_pkg::OFS_W'($urandom));
    send_request(ssa_pkg::OP_FREE, 20'h0ABCD);
    send_request(ssa_pkg::OP_ALLOC, '0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_out_of_slots();
    test_stride_edges();
    test_random_traffic();
    test_stack_full();
    drain_replies();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
